// ===== rtl/nfde_pkg.sv =====
// shared constants, request codes and controller/datapath command and status types
// for the nibble frame buffer draw engine; no dependencies
package nfde_pkg;

   localparam int SCREEN_W    = 160;
   localparam int SCREEN_H    = 128;
   localparam int STORE_BYTES = (SCREEN_W * SCREEN_H + 1) / 2;
   localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int PIX_W       = $clog2(SCREEN_W * SCREEN_H);
   localparam int X_W         = $clog2(SCREEN_W);
   localparam int Y_W         = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
   localparam int COORD_W     = 12;
   localparam int CNT_W       = 9;
   localparam int SEG_W       = 3;

   localparam logic [ADDR_W-1:0] SWEEP_LAST = ADDR_W'(STORE_BYTES - 1);

   typedef enum logic [2:0] {
      OP_FILL    = 3'd0,
      OP_POINT   = 3'd1,
      OP_HRUN    = 3'd2,
      OP_VRUN    = 3'd3,
      OP_RECT    = 3'd4,
      OP_OUTLINE = 3'd5,
      OP_OUTFILL = 3'd6,
      OP_READ    = 3'd7
   } op_type;

   typedef struct packed {
      logic load_req;
      logic sweep_step;
      logic sweep_fill;
      logic seg_load;
      logic seg_next;
      logic pix_addr;
      logic mem_read;
      logic pix_write;
      logic pix_adv;
   } dp_cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic seg_empty;
      logic seg_last;
      logic pix_last;
   } dp_status_type;

endpackage

// ===== rtl/nfde_ctrl.sv =====
// draw engine controller: request sequencing, frame store sweeps and pixel
// read-modify-write steps; depends on nfde_pkg
module nfde_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2:0]              req_type,
   input  nfde_pkg::dp_status_type status,
   output nfde_pkg::dp_cmd_type    cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWEEP,
      ST_SEG,
      ST_PIX_ADDR,
      ST_PIX_READ,
      ST_PIX_WRITE,
      ST_RD_ADDR,
      ST_RD_READ
   } state_type;

   state_type state_ff;
   logic      strobe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.sweep_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) begin
                  unique case (nfde_pkg::op_type'(req_type))
                     nfde_pkg::OP_FILL: state_ff <= ST_SWEEP;
                     nfde_pkg::OP_READ: state_ff <= ST_RD_ADDR;
                     default:           state_ff <= ST_SEG;
                  endcase
               end
            end
            ST_SWEEP: begin
               if (status.sweep_last) begin
                  state_ff  <= ST_IDLE;
                  strobe_ff <= 1'b1;
               end
            end
            ST_SEG: begin
               if (status.seg_empty && status.seg_last) begin
                  state_ff  <= ST_IDLE;
                  strobe_ff <= 1'b1;
               end else if (!status.seg_empty) begin
                  state_ff <= ST_PIX_ADDR;
               end
            end
            ST_PIX_ADDR: state_ff <= ST_PIX_READ;
            ST_PIX_READ: state_ff <= ST_PIX_WRITE;
            ST_PIX_WRITE: begin
               if (status.pix_last) begin
                  if (status.seg_last) begin
                     state_ff  <= ST_IDLE;
                     strobe_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_SEG;
                  end
               end else begin
                  state_ff <= ST_PIX_ADDR;
               end
            end
            ST_RD_ADDR: state_ff <= ST_RD_READ;
            ST_RD_READ: begin
               state_ff  <= ST_IDLE;
               strobe_ff <= 1'b1;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_CLEAR: cmd.sweep_step = 1'b1;
         ST_IDLE:  cmd.load_req   = start;
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            cmd.sweep_fill = 1'b1;
         end
         ST_SEG: begin
            cmd.seg_load = !status.seg_empty;
            cmd.seg_next = status.seg_empty && !status.seg_last;
         end
         ST_PIX_ADDR: cmd.pix_addr = 1'b1;
         ST_PIX_READ: cmd.mem_read = 1'b1;
         ST_PIX_WRITE: begin
            cmd.pix_write = 1'b1;
            cmd.pix_adv   = 1'b1;
            cmd.seg_next  = status.pix_last && !status.seg_last;
         end
         ST_RD_ADDR: cmd.pix_addr = 1'b1;
         ST_RD_READ: cmd.mem_read = 1'b1;
         default:    cmd = '0;
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

   // a result always lands in the idle cycle that follows the last step
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe outside idle");

   // an accepted request leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not start");

   // every write step follows its read step
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX_WRITE) |-> ($past(state_ff) == ST_PIX_READ))
      else $error("pixel write without read");

endmodule

// ===== rtl/nfde_datapath.sv =====
// draw engine datapath: request registers, segment walker, clipping, address
// generation and the frame store; depends on nfde_pkg
module nfde_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  nfde_pkg::dp_cmd_type    cmd,
   output nfde_pkg::dp_status_type status,
   input  logic [2:0]              req_type,
   input  logic signed [10:0]      req_pos_x,
   input  logic signed [10:0]      req_pos_y,
   input  logic [7:0]              req_span_w,
   input  logic [7:0]              req_span_h,
   input  logic [3:0]              req_draw_color,
   input  logic [3:0]              req_fill_color,
   output logic [7:0]              rsp_read_byte,
   output logic                    rsp_was_read
);

   localparam int CW = nfde_pkg::COORD_W;
   localparam int NW = nfde_pkg::CNT_W;
   localparam int SW = nfde_pkg::SEG_W;
   localparam int AW = nfde_pkg::ADDR_W;

   localparam logic [SW-1:0] SEG_TOP    = SW'(0);
   localparam logic [SW-1:0] SEG_BOTTOM = SW'(1);
   localparam logic [SW-1:0] SEG_LEFT   = SW'(2);
   localparam logic [SW-1:0] SEG_RIGHT  = SW'(3);
   localparam logic [SW-1:0] SEG_INSIDE = SW'(4);

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic [NW-1:0]        cw;
      logic [NW-1:0]        ch;
      logic [3:0]           color;
   } seg_geom_type;

   function automatic seg_geom_type seg_geom(
      input nfde_pkg::op_type     op,
      input logic [SW-1:0]        idx,
      input logic signed [CW-1:0] x,
      input logic signed [CW-1:0] y,
      input logic [7:0]           w,
      input logic [7:0]           h,
      input logic [3:0]           dc,
      input logic [3:0]           fc
   );
      seg_geom_type g;
      logic [NW-1:0] w9;
      logic [NW-1:0] h9;
      w9 = NW'(w);
      h9 = NW'(h);
      g.sx    = x;
      g.sy    = y;
      g.cw    = NW'(1);
      g.ch    = NW'(1);
      g.color = dc;
      case (op) inside
         nfde_pkg::OP_HRUN: g.cw = w9;
         nfde_pkg::OP_VRUN: g.ch = h9;
         nfde_pkg::OP_RECT: begin
            g.cw = w9 + NW'(1);
            g.ch = h9 + NW'(1);
         end
         nfde_pkg::OP_OUTLINE, nfde_pkg::OP_OUTFILL: begin
            case (idx)
               SEG_TOP: g.cw = w9;
               SEG_BOTTOM: begin
                  g.cw = w9;
                  g.sy = y + $signed({4'd0, h});
               end
               SEG_LEFT: g.ch = h9;
               SEG_RIGHT: begin
                  g.ch = h9;
                  g.sx = x + $signed({4'd0, w});
               end
               default: begin
                  g.sx    = x + CW'(1);
                  g.sy    = y + CW'(1);
                  g.cw    = (w9 == '0) ? '0 : w9 - NW'(1);
                  g.ch    = (h9 == '0) ? '0 : h9 - NW'(1);
                  g.color = fc;
               end
            endcase
         end
         default: g.cw = NW'(1);
      endcase
      return g;
   endfunction

   // request registers
   nfde_pkg::op_type     op_ff;
   logic signed [CW-1:0] x_ff;
   logic signed [CW-1:0] y_ff;
   logic [7:0]           w_ff;
   logic [7:0]           h_ff;
   logic [3:0]           dc_ff;
   logic [3:0]           fc_ff;

   // walker
   logic [SW-1:0]        seg_idx_ff, seg_idx_in;
   logic [AW-1:0]        sweep_cnt_ff, sweep_cnt_in;
   logic signed [CW-1:0] seg_x_ff;
   logic [NW-1:0]        cnt_w_ff;
   logic [NW-1:0]        cnt_h_ff;
   logic [3:0]           color_ff;
   logic signed [CW-1:0] cur_x_ff, cur_x_in;
   logic signed [CW-1:0] cur_y_ff, cur_y_in;
   logic [NW-1:0]        col_ff, col_in;
   logic [NW-1:0]        row_ff, row_in;

   // pixel access
   logic                 in_ok_ff;
   logic [AW-1:0]        addr_ff;
   logic [7:0]           rd_data_ff;
   logic [7:0]           store_mem [nfde_pkg::STORE_BYTES];

   seg_geom_type                 geom;
   logic                         seg_last;
   logic                         col_last;
   logic                         on_screen;
   logic [nfde_pkg::X_W-1:0]     cx;
   logic [nfde_pkg::Y_W-1:0]     cy;
   logic [nfde_pkg::PIX_W-1:0]   pix_idx;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [7:0]                   wr_data;
   logic [7:0]                   merged;

   assign geom = seg_geom(op_ff, seg_idx_ff, x_ff, y_ff, w_ff, h_ff, dc_ff, fc_ff);

   always_comb begin
      case (op_ff)
         nfde_pkg::OP_OUTLINE: seg_last = (seg_idx_ff == SEG_RIGHT);
         nfde_pkg::OP_OUTFILL: seg_last = (seg_idx_ff == SEG_INSIDE);
         default:              seg_last = 1'b1;
      endcase
   end

   assign col_last = (col_ff == cnt_w_ff - NW'(1));

   assign status.sweep_last = (sweep_cnt_ff == nfde_pkg::SWEEP_LAST);
   assign status.seg_empty  = (geom.cw == '0) || (geom.ch == '0);
   assign status.seg_last   = seg_last;
   assign status.pix_last   = col_last && (row_ff == cnt_h_ff - NW'(1));

   // clip and byte address
   assign on_screen = !cur_x_ff[CW-1] && !cur_y_ff[CW-1]
                      && (cur_x_ff < $signed(CW'(nfde_pkg::SCREEN_W)))
                      && (cur_y_ff < $signed(CW'(nfde_pkg::SCREEN_H)));
   assign cx      = cur_x_ff[nfde_pkg::X_W-1:0];
   assign cy      = cur_y_ff[nfde_pkg::Y_W-1:0];
   assign pix_idx = nfde_pkg::PIX_W'(cy * nfde_pkg::SCREEN_W) + nfde_pkg::PIX_W'(cx);

   // walker next values
   always_comb begin
      seg_idx_in   = seg_idx_ff;
      sweep_cnt_in = sweep_cnt_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (cmd.load_req) begin
         seg_idx_in = '0;
         cur_x_in   = {req_pos_x[10], req_pos_x};
         cur_y_in   = {req_pos_y[10], req_pos_y};
      end
      if (cmd.seg_next) seg_idx_in = seg_idx_ff + SW'(1);
      if (cmd.sweep_step) begin
         sweep_cnt_in = status.sweep_last ? '0 : sweep_cnt_ff + AW'(1);
      end
      if (cmd.seg_load) begin
         cur_x_in = geom.sx;
         cur_y_in = geom.sy;
         col_in   = '0;
         row_in   = '0;
      end
      if (cmd.pix_adv) begin
         if (col_last) begin
            col_in   = '0;
            cur_x_in = seg_x_ff;
            row_in   = row_ff + NW'(1);
            cur_y_in = cur_y_ff + CW'(1);
         end else begin
            col_in   = col_ff + NW'(1);
            cur_x_in = cur_x_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_idx_ff   <= '0;
         sweep_cnt_ff <= '0;
      end else begin
         seg_idx_ff   <= seg_idx_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      if (cmd.load_req) begin
         op_ff <= nfde_pkg::op_type'(req_type);
         x_ff  <= {req_pos_x[10], req_pos_x};
         y_ff  <= {req_pos_y[10], req_pos_y};
         w_ff  <= req_span_w;
         h_ff  <= req_span_h;
         dc_ff <= req_draw_color;
         fc_ff <= req_fill_color;
      end
      if (cmd.seg_load) begin
         seg_x_ff <= geom.sx;
         cnt_w_ff <= geom.cw;
         cnt_h_ff <= geom.ch;
         color_ff <= geom.color;
      end
      if (cmd.pix_addr) begin
         in_ok_ff <= on_screen;
         addr_ff  <= on_screen ? AW'(pix_idx >> 1) : '0;
      end
   end

   // nibble merge: odd column in the high nibble
   assign merged = cur_x_ff[0] ? {color_ff, rd_data_ff[3:0]} : {rd_data_ff[7:4], color_ff};

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = merged;
      if (cmd.sweep_step) begin
         wr_en   = 1'b1;
         wr_addr = sweep_cnt_ff;
         wr_data = cmd.sweep_fill ? {dc_ff, dc_ff} : 8'h00;
      end else if (cmd.pix_write && in_ok_ff) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= wr_data;
      if (cmd.mem_read) rd_data_ff <= store_mem[addr_ff];
   end

   assign rsp_was_read  = (op_ff == nfde_pkg::OP_READ);
   assign rsp_read_byte = (rsp_was_read && in_ok_ff) ? rd_data_ff : 8'h00;

endmodule

// ===== rtl/nibble_framebuffer_draw_engine_unit.sv =====
// top level of the 4-bit-per-pixel frame buffer draw engine; joins nfde_ctrl and
// nfde_datapath; depends on nfde_pkg
// after reset busy stays high while the frame store is cleared
// read: address and read states, then the result strobe as the engine returns to idle
// drawing: segment state per segment (up to five), address/read/write per pixel, strobe the cycle after
// fill screen: one store byte per cycle over the whole store, strobe the cycle after
// single-port frame store read-modify-write sets the pixel rate; next request taken in the strobe cycle
module nibble_framebuffer_draw_engine_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_type,
   input  logic signed [10:0] req_pos_x,
   input  logic signed [10:0] req_pos_y,
   input  logic [7:0]         req_span_w,
   input  logic [7:0]         req_span_h,
   input  logic [3:0]         req_draw_color,
   input  logic [3:0]         req_fill_color,
   output logic               rsp_strobe,
   output logic [7:0]         rsp_read_byte,
   output logic               rsp_was_read
);

   nfde_pkg::dp_cmd_type    cmd;
   nfde_pkg::dp_status_type status;

   nfde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   nfde_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_type       (req_type),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_span_w     (req_span_w),
      .req_span_h     (req_span_h),
      .req_draw_color (req_draw_color),
      .req_fill_color (req_fill_color),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_was_read   (rsp_was_read)
   );

endmodule

// ===== bench/nibble_framebuffer_draw_engine_unit_test.sv =====
// self-checking bench for nibble_framebuffer_draw_engine_unit: drives drawing and read requests,
// tracks the 4-bit frame store in a scoreboard class and checks every response in order
// depends on nfde_pkg and the draw engine top level
module nibble_framebuffer_draw_engine_unit_test;

   localparam int RANDOM_ITEMS = 1880;
   localparam int STALL_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      logic [7:0] read_byte;
      logic       was_read;
   } draw_reply_type;

   class frame_scoreboard_type;
      logic [7:0]     store_bytes [nfde_pkg::STORE_BYTES];
      draw_reply_type awaited_replies [$];
      int             mismatches;

      function new();
         foreach (store_bytes[i]) store_bytes[i] = 8'h00;
         mismatches = 0;
      endfunction

      function bit on_screen(int x, int y);
         return x >= 0 && y >= 0 && x < nfde_pkg::SCREEN_W && y < nfde_pkg::SCREEN_H;
      endfunction

      function void set_pixel(int x, int y, logic [3:0] c);
         int idx;
         if (!on_screen(x, y)) return;
         idx = (y * nfde_pkg::SCREEN_W + x) >> 1;
         if (x[0]) store_bytes[idx][7:4] = c;
         else store_bytes[idx][3:0] = c;
      endfunction

      function void row_run(int x, int y, int w, logic [3:0] c);
         for (int i = x; i < x + w; i++) set_pixel(i, y, c);
      endfunction

      function void column_run(int x, int y, int h, logic [3:0] c);
         for (int j = y; j < y + h; j++) set_pixel(x, j, c);
      endfunction

      function void block_fill(int x, int y, int w, int h, logic [3:0] c);
         for (int i = x; i < x + w + 1; i++) column_run(i, y, h + 1, c);
      endfunction

      function void box_edges(int x, int y, int w, int h, logic [3:0] c);
         row_run(x, y, w, c);
         row_run(x, y + h, w, c);
         column_run(x, y, h, c);
         column_run(x + w, y, h, c);
      endfunction

      function void note_request(nfde_pkg::op_type op, int x, int y, int w, int h,
                                 logic [3:0] dc, logic [3:0] fc);
         draw_reply_type r;
         r.read_byte = 8'h00;
         r.was_read  = 1'b0;
         case (op)
            nfde_pkg::OP_FILL:    foreach (store_bytes[i]) store_bytes[i] = {dc, dc};
            nfde_pkg::OP_POINT:   set_pixel(x, y, dc);
            nfde_pkg::OP_HRUN:    row_run(x, y, w, dc);
            nfde_pkg::OP_VRUN:    column_run(x, y, h, dc);
            nfde_pkg::OP_RECT:    block_fill(x, y, w, h, dc);
            nfde_pkg::OP_OUTLINE: box_edges(x, y, w, h, dc);
            nfde_pkg::OP_OUTFILL: begin
               box_edges(x, y, w, h, dc);
               block_fill(x + 1, y + 1, w - 2, h - 2, fc);
            end
            nfde_pkg::OP_READ: begin
               r.was_read = 1'b1;
               if (on_screen(x, y))
                  r.read_byte = store_bytes[(y * nfde_pkg::SCREEN_W + x) >> 1];
            end
         endcase
         awaited_replies.push_back(r);
      endfunction

      function void check_response(logic [7:0] rb, logic wr);
         draw_reply_type exp_r;
         if (awaited_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: read_byte %h was_read %b", rb, wr);
            return;
         end
         exp_r = awaited_replies.pop_front();
         if (rb !== exp_r.read_byte || wr !== exp_r.was_read) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected read_byte %h was_read %b, got %h %b",
                        exp_r.read_byte, exp_r.was_read, rb, wr);
         end
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction
   endclass

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               start          = 1'b0;
   logic               busy;
   logic [2:0]         req_type       = 3'd0;
   logic signed [10:0] req_pos_x      = 11'sd0;
   logic signed [10:0] req_pos_y      = 11'sd0;
   logic [7:0]         req_span_w     = 8'd0;
   logic [7:0]         req_span_h     = 8'd0;
   logic [3:0]         req_draw_color = 4'd0;
   logic [3:0]         req_fill_color = 4'd0;
   logic               rsp_strobe;
   logic [7:0]         rsp_read_byte;
   logic               rsp_was_read;

   frame_scoreboard_type sb;
   bit                   idling_on   = 1'b1;
   int                   idle_cycles = 0;

   nibble_framebuffer_draw_engine_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_span_w     (req_span_w),
      .req_span_h     (req_span_h),
      .req_draw_color (req_draw_color),
      .req_fill_color (req_fill_color),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_was_read   (rsp_was_read)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_read_byte, rsp_was_read);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   function automatic int random_coord(int lo, int hi);
      if ($urandom_range(0, 99) < 15) return int'($urandom_range(0, 2047)) - 1024;
      return int'($urandom_range(0, hi - lo)) + lo;
   endfunction

   task automatic issue_request(input nfde_pkg::op_type op, input logic signed [10:0] x, y,
                                input logic [7:0] w, h, input logic [3:0] dc, fc);
      while (idling_on && $urandom_range(0, 99) < 33) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= op;
      req_pos_x      <= x;
      req_pos_y      <= y;
      req_span_w     <= w;
      req_span_h     <= h;
      req_draw_color <= dc;
      req_fill_color <= fc;
      do @(posedge clock); while (busy);
      sb.note_request(op, x, y, w, h, dc, fc);
   endtask

   initial begin
      int                 pick;
      int                 sel;
      int                 anchor_x;
      int                 anchor_y;
      nfde_pkg::op_type   op;
      logic signed [10:0] x;
      logic signed [10:0] y;
      logic [7:0]         w;
      logic [7:0]         h;
      logic [3:0]         dc;
      logic [3:0]         fc;

      sb = new();
      anchor_x = 0;
      anchor_y = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // store cleared at reset, then screen fills at both color extremes
      issue_request(nfde_pkg::OP_READ,    0,     0,     0,   0,   4'h0, 4'h0);
      issue_request(nfde_pkg::OP_FILL,    -1024, 1023,  255, 255, 4'hF, 4'h0);
      issue_request(nfde_pkg::OP_READ,    159,   127,   0,   0,   4'h0, 4'hF);
      issue_request(nfde_pkg::OP_FILL,    1023,  -1024, 0,   0,   4'h0, 4'hF);
      // nibble packing and clipped points and reads
      issue_request(nfde_pkg::OP_POINT,   0,     0,     0,   0,   4'h5, 4'h0);
      issue_request(nfde_pkg::OP_POINT,   1,     0,     0,   0,   4'hC, 4'h0);
      issue_request(nfde_pkg::OP_POINT,   -1,    0,     0,   0,   4'hF, 4'h0);
      issue_request(nfde_pkg::OP_POINT,   1023,  127,   0,   0,   4'hF, 4'h0);
      issue_request(nfde_pkg::OP_READ,    0,     0,     0,   0,   4'h0, 4'h0);
      issue_request(nfde_pkg::OP_READ,    -1,    5,     0,   0,   4'h0, 4'h0);
      issue_request(nfde_pkg::OP_READ,    5,     128,   0,   0,   4'h0, 4'h0);
      // even-aligned run starting left of the screen, runs clipped at the edges, empty runs
      issue_request(nfde_pkg::OP_HRUN,    -4,    2,     9,   0,   4'h3, 4'h0);
      issue_request(nfde_pkg::OP_READ,    4,     2,     0,   0,   4'h0, 4'h0);
      issue_request(nfde_pkg::OP_HRUN,    150,   127,   255, 0,   4'h7, 4'h0);
      issue_request(nfde_pkg::OP_HRUN,    6,     2,     0,   0,   4'hE, 4'h0);
      issue_request(nfde_pkg::OP_VRUN,    159,   -4,    0,   255, 4'h9, 4'h0);
      issue_request(nfde_pkg::OP_VRUN,    6,     2,     0,   0,   4'hE, 4'h0);
      issue_request(nfde_pkg::OP_READ,    158,   0,     0,   0,   4'h0, 4'h0);
      // inclusive rectangle, outline corner, outline with and without inside
      issue_request(nfde_pkg::OP_RECT,    10,    10,    0,   0,   4'hD, 4'h0);
      issue_request(nfde_pkg::OP_OUTLINE, 20,    20,    6,   4,   4'h2, 4'h0);
      issue_request(nfde_pkg::OP_READ,    26,    24,    0,   0,   4'h0, 4'h0);
      issue_request(nfde_pkg::OP_OUTFILL, 30,    30,    5,   5,   4'h6, 4'hF);
      issue_request(nfde_pkg::OP_OUTFILL, 40,    40,    1,   1,   4'h1, 4'h8);
      issue_request(nfde_pkg::OP_OUTLINE, -100,  -100,  255, 255, 4'h4, 4'h0);
      issue_request(nfde_pkg::OP_OUTFILL, 100,   100,   255, 2,   4'hB, 4'h0);
      issue_request(nfde_pkg::OP_RECT,    100,   60,    255, 255, 4'h8, 4'h0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idling_on = !(n >= 700 && n < 1000);
         pick = $urandom_range(0, 999);
         dc   = 4'($urandom);
         fc   = 4'($urandom);
         x    = 11'(random_coord(-10, nfde_pkg::SCREEN_W + 9));
         y    = 11'(random_coord(-10, nfde_pkg::SCREEN_H + 9));
         w    = 8'($urandom);
         h    = 8'($urandom);
         if (pick < 4) begin
            op = nfde_pkg::OP_FILL;
         end else if (pick < 354) begin
            op  = nfde_pkg::OP_READ;
            sel = $urandom_range(0, 9);
            if (sel < 8) begin
               x = 11'(anchor_x + int'($urandom_range(0, 20)) - 4);
               y = 11'(anchor_y + int'($urandom_range(0, 12)) - 2);
            end else if (sel == 8) begin
               x = 11'($urandom_range(0, nfde_pkg::SCREEN_W - 1));
               y = 11'($urandom_range(0, nfde_pkg::SCREEN_H - 1));
            end
         end else begin
            op  = nfde_pkg::op_type'($urandom_range(1, 6));
            sel = $urandom_range(0, 9);
            if (op == nfde_pkg::OP_RECT || op == nfde_pkg::OP_OUTFILL) begin
               // big areas are slow, so only one span may be wide
               if (sel == 0) begin
                  h = 8'($urandom_range(0, 3));
               end else if (sel == 1) begin
                  w = 8'($urandom_range(0, 3));
               end else begin
                  w = 8'($urandom_range(0, 15));
                  h = 8'($urandom_range(0, 15));
               end
            end else if (sel < 7) begin
               w = 8'($urandom_range(0, 15));
               h = 8'($urandom_range(0, 15));
            end
            if (x >= -10 && x < nfde_pkg::SCREEN_W + 10 &&
                y >= -10 && y < nfde_pkg::SCREEN_H + 10) begin
               anchor_x = x;
               anchor_y = y;
            end
         end
         issue_request(op, x, y, w, h, dc, fc);
      end
      start <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
